// File: sv/batsp_pkg.sv
// ============================================================================
// batsp_pkg - shared types and constants for the aux tag stream parser
// Result kinds, type codes, the queue entry between front and back, and the
// small lookups used to classify bytes.
// ============================================================================
`default_nettype none

package batsp_pkg;

    localparam int unsigned QueueDepth = 4;

    // result kinds
    localparam logic [2:0] KIND_SCALAR  = 3'd0;
    localparam logic [2:0] KIND_CHAR    = 3'd1;
    localparam logic [2:0] KIND_STR_END = 3'd2;
    localparam logic [2:0] KIND_ACCEPT  = 3'd3;
    localparam logic [2:0] KIND_REJECT  = 3'd4;

    // type codes
    localparam logic [3:0] TYPE_A  = 4'd0;
    localparam logic [3:0] TYPE_LC = 4'd1;
    localparam logic [3:0] TYPE_UC = 4'd2;
    localparam logic [3:0] TYPE_LS = 4'd3;
    localparam logic [3:0] TYPE_US = 4'd4;
    localparam logic [3:0] TYPE_LI = 4'd5;
    localparam logic [3:0] TYPE_UI = 4'd6;
    localparam logic [3:0] TYPE_F  = 4'd7;
    localparam logic [3:0] TYPE_Z  = 4'd8;

    localparam logic [7:0] NUL_BYTE = 8'h00;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] name_pair;
        logic [3:0]  type_code;
        logic [31:0] value;
    } t_result;

    // everything one byte causes: an optional tag result, then an optional close
    typedef struct packed {
        logic    has_res;
        t_result res;
        logic    has_close;
        logic    close_acc;
    } t_entry;

    typedef struct packed {
        logic       hit;
        logic [3:0] code;
    } t_type_hit;

    function automatic logic alnum_byte(input logic [7:0] b);
        logic r;
        r = ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h5a)) ||
            ((b >= 8'h61) && (b <= 8'h7a));
        return r;
    endfunction

    function automatic t_type_hit type_lookup(input logic [7:0] b);
        t_type_hit r;
        r.hit  = 1'b1;
        r.code = TYPE_A;
        case (b)
            8'h41:   r.code = TYPE_A;   // A
            8'h63:   r.code = TYPE_LC;  // c
            8'h43:   r.code = TYPE_UC;  // C
            8'h73:   r.code = TYPE_LS;  // s
            8'h53:   r.code = TYPE_US;  // S
            8'h69:   r.code = TYPE_LI;  // i
            8'h49:   r.code = TYPE_UI;  // I
            8'h66:   r.code = TYPE_F;   // f
            8'h5a:   r.code = TYPE_Z;   // Z
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] type_size(input logic [3:0] code);
        logic [2:0] r;
        case (code)
            TYPE_A, TYPE_LC, TYPE_UC: r = 3'd1;
            TYPE_LS, TYPE_US:         r = 3'd2;
            TYPE_LI, TYPE_UI, TYPE_F: r = 3'd4;
            default:                  r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/batsp_if.sv
// ============================================================================
// batsp_if - byte and result channels of the aux tag stream parser
// Valid/ready channels; a beat moves when valid and ready are both high.
// ============================================================================
`default_nettype none

interface batsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       final_byte;

    modport source (output valid, output byte_value, output final_byte, input ready);
    modport sink   (input valid, input byte_value, input final_byte, output ready);
endinterface

interface batsp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] name_pair;
    logic [3:0]  type_code;
    logic [31:0] value;
    logic        run_end;

    modport source (output valid, output kind, output name_pair, output type_code,
                    output value, output run_end, input ready);
    modport sink   (input valid, input kind, input name_pair, input type_code,
                    input value, input run_end, output ready);
endinterface

`default_nettype wire

// File: sv/batsp_front.sv
// ============================================================================
// batsp_front - byte classifier and tag state machine
// Takes one byte per beat, advances the header/value/string state and
// pushes the results the byte causes as one queue entry.
// ============================================================================
`default_nettype none

module batsp_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_last,
    input  wire logic              i_q_full,
    output logic                   o_ready,
    output logic                   o_push,
    output batsp_pkg::t_entry      o_entry
);

    localparam logic [2:0] PH_WAIT_FIRST = 3'd0;
    localparam logic [2:0] PH_NAME2      = 3'd1;
    localparam logic [2:0] PH_TYPE       = 3'd2;
    localparam logic [2:0] PH_VALUE      = 3'd3;
    localparam logic [2:0] PH_STRING     = 3'd4;
    localparam logic [2:0] PH_NAME1      = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_name, n_name;
    logic [3:0]  r_type, n_type;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_left, n_left;
    logic        r_any, n_any;
    logic        r_closed;

    logic                  accept;
    logic                  emit;
    logic                  close;
    logic                  close_acc;
    batsp_pkg::t_result    res;
    batsp_pkg::t_type_hit  th;
    logic [2:0]            pos;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready && !r_closed;

    always_comb begin
        n_phase   = r_phase;
        n_name    = r_name;
        n_type    = r_type;
        n_acc     = r_acc;
        n_left    = r_left;
        n_any     = r_any;
        emit      = 1'b0;
        close     = 1'b0;
        close_acc = 1'b0;
        res       = '0;
        th        = batsp_pkg::type_lookup(i_byte);
        pos       = batsp_pkg::type_size(r_type) - r_left;
        case (r_phase)
            PH_NAME1: begin
                n_name  = {i_byte, 8'h00};
                n_phase = PH_NAME2;
            end
            PH_NAME2: begin
                if (!r_any && !batsp_pkg::alnum_byte(i_byte)) begin
                    close = 1'b1;
                end else begin
                    n_name  = {r_name[15:8], i_byte};
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (i_byte == batsp_pkg::NUL_BYTE) begin
                    close     = 1'b1;
                    close_acc = r_any;
                end else if (!th.hit) begin
                    close = 1'b1;
                end else begin
                    n_type = th.code;
                    n_acc  = '0;
                    if (th.code == batsp_pkg::TYPE_Z) begin
                        n_left  = '0;
                        n_phase = PH_STRING;
                    end else begin
                        n_left  = batsp_pkg::type_size(th.code);
                        n_phase = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                // little-endian: byte lands at its position within the value
                n_acc = r_acc | ({24'h000000, i_byte} << {pos[1:0], 3'b000});
                if (r_left != 3'd0) begin
                    n_left = r_left - 3'd1;
                end
                if (n_left == 3'd0) begin
                    emit           = 1'b1;
                    res.kind       = batsp_pkg::KIND_SCALAR;
                    res.name_pair  = r_name;
                    res.type_code  = r_type;
                    res.value      = n_acc;
                    n_any          = 1'b1;
                    n_phase        = PH_NAME1;
                end
            end
            PH_STRING: begin
                emit          = 1'b1;
                res.name_pair = r_name;
                res.type_code = batsp_pkg::TYPE_Z;
                if (i_byte != batsp_pkg::NUL_BYTE) begin
                    res.kind  = batsp_pkg::KIND_CHAR;
                    res.value = {24'h000000, i_byte};
                end else begin
                    res.kind = batsp_pkg::KIND_STR_END;
                    n_any    = 1'b1;
                    n_phase  = PH_NAME1;
                end
            end
            default: begin
                if (batsp_pkg::alnum_byte(i_byte)) begin
                    n_name  = {i_byte, 8'h00};
                    n_phase = PH_NAME2;
                end
            end
        endcase
        // end of area: clean only on a tag boundary after at least one tag
        if (i_last && !close) begin
            close     = 1'b1;
            close_acc = (n_phase == PH_NAME1) && n_any;
        end
    end

    assign o_push            = accept && (emit || close);
    assign o_entry.has_res   = emit;
    assign o_entry.res       = res;
    assign o_entry.has_close = close;
    assign o_entry.close_acc = close_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT_FIRST;
            r_any    <= 1'b0;
            r_closed <= 1'b0;
            r_left   <= '0;
            r_type   <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_any    <= n_any;
            r_left   <= n_left;
            r_type   <= n_type;
            r_closed <= close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_name <= n_name;
            r_acc  <= n_acc;
        end
    end

    a_closed_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_closed |=> r_closed)
        else $error("list reopened after close");

    a_no_push_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_closed |-> !o_push)
        else $error("entry pushed after list close");

    a_value_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VALUE) |-> (r_left != 3'd0))
        else $error("value phase with no bytes left");

endmodule

`default_nettype wire

// File: sv/batsp_queue.sv
// ============================================================================
// batsp_queue - short entry queue between front and back
// Register FIFO of per-byte result entries.
// ============================================================================
`default_nettype none

module batsp_queue #(
    parameter int unsigned DEPTH = batsp_pkg::QueueDepth
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire batsp_pkg::t_entry i_entry,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_valid,
    output batsp_pkg::t_entry      o_entry
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    batsp_pkg::t_entry r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr, r_rd;
    logic [CntW-1:0]   r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == FullCnt);
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LastPtr) ? '0 : r_wr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LastPtr) ? '0 : r_rd + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FullCnt)
        else $error("queue count beyond depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: sv/batsp_back.sv
// ============================================================================
// batsp_back - result sequencer
// Pops queue entries and drives one result per beat from an output register,
// the tag result first and the list close after it.
// ============================================================================
`default_nettype none

module batsp_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire batsp_pkg::t_entry i_entry,
    output logic                   o_pop,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output batsp_pkg::t_result     o_res,
    output logic                   o_run_end
);

    logic               r_out_valid, n_out_valid;
    batsp_pkg::t_result r_res, n_res;
    logic               r_run_end, n_run_end;
    logic               r_pend, n_pend;
    logic               r_pend_acc, n_pend_acc;
    logic               load;

    assign load = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_res       = r_res;
        n_run_end   = r_run_end;
        n_pend      = r_pend;
        n_pend_acc  = r_pend_acc;
        o_pop       = 1'b0;
        if (load) begin
            n_out_valid = 1'b0;
            if (r_pend) begin
                // second beat of a byte: list close
                n_out_valid = 1'b1;
                n_res       = '0;
                n_res.kind  = r_pend_acc ? batsp_pkg::KIND_ACCEPT : batsp_pkg::KIND_REJECT;
                n_run_end   = 1'b1;
                n_pend      = 1'b0;
            end else if (i_q_valid) begin
                o_pop       = 1'b1;
                n_out_valid = 1'b1;
                if (i_entry.has_res) begin
                    n_res      = i_entry.res;
                    n_run_end  = !i_entry.has_close;
                    n_pend     = i_entry.has_close;
                    n_pend_acc = i_entry.close_acc;
                end else begin
                    n_res      = '0;
                    n_res.kind = i_entry.close_acc ? batsp_pkg::KIND_ACCEPT
                                                   : batsp_pkg::KIND_REJECT;
                    n_run_end  = 1'b1;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;
    assign o_run_end   = r_run_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res      <= n_res;
        r_run_end  <= n_run_end;
        r_pend_acc <= n_pend_acc;
    end

    a_pend_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_out_valid && !r_run_end))
        else $error("pending close without its leading result on the output");

    a_no_pop_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !o_pop)
        else $error("queue popped while a close is pending");

    a_close_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.kind == batsp_pkg::KIND_ACCEPT ||
                         r_res.kind == batsp_pkg::KIND_REJECT)) |-> r_run_end)
        else $error("list close not marked as last result of its byte");

endmodule

`default_nettype wire

// File: sv/bam_aux_tag_stream_parser.sv
// ============================================================================
// bam_aux_tag_stream_parser - streaming parser for BAM auxiliary tags
// Byte-in, result-out parser of the aux field area with list accept/reject.
// ============================================================================
// Feed the aux area one byte per beat on i_in, with final_byte on the last
// byte. Results come out on o_out, one per beat: a scalar tag (name, type
// code, raw little-endian value), a string character, a string end, and a
// final list accept or reject; run_end marks the last result of each byte.
// The input takes one byte per cycle unless the queue is full; a byte makes
// at most two results, and the output register sends one result per cycle
// while o_out is ready, so the sustained rate is one byte per cycle except
// where a byte yields two results (a tag and the list close). Between the
// byte classifier and the result sequencer, a QUEUE_DEPTH-entry queue lets
// the input keep running while the output is stalled, until the queue fills.
// After the list closes all further bytes are taken and dropped until reset.
// ============================================================================
`default_nettype none

module bam_aux_tag_stream_parser #(
    parameter int unsigned QUEUE_DEPTH = batsp_pkg::QueueDepth
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    batsp_in_if.sink    i_in,
    batsp_out_if.source o_out
);

    // front to queue
    logic               front_push;
    batsp_pkg::t_entry  front_entry;
    // queue to back
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    batsp_pkg::t_entry  q_entry;
    // back to output port
    batsp_pkg::t_result out_res;

    // classify each byte and advance the tag state
    batsp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_byte   (i_in.byte_value),
        .i_last   (i_in.final_byte),
        .i_q_full (q_full),
        .o_ready  (i_in.ready),
        .o_push   (front_push),
        .o_entry  (front_entry)
    );

    // decoupling queue, one entry per byte that makes results
    batsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // serialize entries into result beats
    batsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_entry     (q_entry),
        .o_pop       (q_pop),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_res       (out_res),
        .o_run_end   (o_out.run_end)
    );

    assign o_out.kind      = out_res.kind;
    assign o_out.name_pair = out_res.name_pair;
    assign o_out.type_code = out_res.type_code;
    assign o_out.value     = out_res.value;

endmodule

`default_nettype wire

// File: bench/bam_aux_tag_stream_parser_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// bam_aux_tag_stream_parser_tb - self-checking bench for the aux tag parser
// Streams one long BAM aux tag list through the parser. The list starts with
// junk bytes and directed extremes, continues with random well-formed tags,
// and ends in one randomly chosen way: zero type, bad type, final byte on a
// tag boundary, or truncation. It then sends a few bytes that must be dropped.
// A behavioral parser predicts every result beat; the monitor compares each
// beat field by field, in order, while both sides idle at random.
// ============================================================================

module bam_aux_tag_stream_parser_tb;

    localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 32;    // queue depth plus output register, with margin
    localparam int BYTE_COUNT   = 400;

    // type letters and value lengths, indexed by type code
    localparam logic [7:0] TYPE_CHAR [9] = '{8'h41, 8'h63, 8'h43, 8'h73, 8'h53,
                                             8'h69, 8'h49, 8'h66, 8'h5a};
    localparam int TYPE_LEN [9] = '{1, 1, 1, 2, 2, 4, 4, 4, 0};

    typedef enum logic [2:0] {
        ST_SKIP_LEAD,
        ST_NAME_LO,
        ST_TYPE,
        ST_VALUE,
        ST_STRING,
        ST_NAME_HI
    } t_parse_state;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_aux_byte;

    typedef struct packed {
        batsp_pkg::t_result res;
        logic               run_end;
    } t_result_beat;

    logic i_clk;
    logic i_rst_n;

    batsp_in_if  in_if();
    batsp_out_if out_if();

    bam_aux_tag_stream_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_aux_byte    aux_bytes [$];    // bytes still to be sent
    t_result_beat pending_res [$];  // predicted result beats, oldest first

    // parser state as predicted
    t_parse_state prs_state;
    logic [15:0]  prs_name;
    logic [3:0]   prs_type;
    logic [31:0]  prs_acc;
    int           prs_left;
    logic         prs_tag_seen;
    logic         prs_closed;

    logic in_taken;
    int   beats_in;
    int   quiet_cycles;
    int   mismatches;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic alnum_byte(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    // predict the result beats of one accepted byte
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        batsp_pkg::t_result res [2];
        int      n;
        int      pos;
        logic    hit;
        logic    close_now;
        logic    close_ok;
        logic [3:0] code;
        n         = 0;
        hit       = 1'b0;
        close_now = 1'b0;
        close_ok  = 1'b0;
        code      = batsp_pkg::TYPE_A;
        if (!prs_closed) begin
            case (prs_state)
                ST_NAME_HI: begin
                    prs_name  = {b, 8'h00};
                    prs_state = ST_NAME_LO;
                end
                ST_NAME_LO: begin
                    // only the very first header must have an alphanumeric name
                    if (!prs_tag_seen && !alnum_byte(b)) begin
                        close_now = 1'b1;
                    end else begin
                        prs_name[7:0] = b;
                        prs_state     = ST_TYPE;
                    end
                end
                ST_TYPE: begin
                    if (b == batsp_pkg::NUL_BYTE) begin
                        close_now = 1'b1;
                        close_ok  = prs_tag_seen;
                    end else begin
                        for (int t = 0; t < 9; t++) begin
                            if (!hit && TYPE_CHAR[t] == b) begin
                                hit  = 1'b1;
                                code = t[3:0];
                            end
                        end
                        if (!hit) begin
                            close_now = 1'b1;
                        end else begin
                            prs_type = code;
                            prs_acc  = '0;
                            prs_left = TYPE_LEN[code];
                            prs_state = (code == batsp_pkg::TYPE_Z) ? ST_STRING : ST_VALUE;
                        end
                    end
                end
                ST_VALUE: begin
                    // little-endian assembly
                    pos     = TYPE_LEN[prs_type] - prs_left;
                    prs_acc = prs_acc | (32'(b) << (8 * pos));
                    prs_left--;
                    if (prs_left == 0) begin
                        res[n] = '{kind: batsp_pkg::KIND_SCALAR, name_pair: prs_name,
                                   type_code: prs_type, value: prs_acc};
                        n++;
                        prs_tag_seen = 1'b1;
                        prs_state    = ST_NAME_HI;
                    end
                end
                ST_STRING: begin
                    if (b != batsp_pkg::NUL_BYTE) begin
                        res[n] = '{kind: batsp_pkg::KIND_CHAR, name_pair: prs_name,
                                   type_code: batsp_pkg::TYPE_Z, value: {24'h0, b}};
                    end else begin
                        res[n] = '{kind: batsp_pkg::KIND_STR_END, name_pair: prs_name,
                                   type_code: batsp_pkg::TYPE_Z, value: 32'h0};
                        prs_tag_seen = 1'b1;
                        prs_state    = ST_NAME_HI;
                    end
                    n++;
                end
                default: begin
                    // junk before the first header is skipped
                    if (alnum_byte(b)) begin
                        prs_name  = {b, 8'h00};
                        prs_state = ST_NAME_LO;
                    end
                end
            endcase
            // final byte closes an open list: accepted only on a tag boundary
            if (!close_now && fin) begin
                close_now = 1'b1;
                close_ok  = (prs_state == ST_NAME_HI) && prs_tag_seen;
            end
            if (close_now) begin
                res[n] = '{kind: close_ok ? batsp_pkg::KIND_ACCEPT : batsp_pkg::KIND_REJECT,
                           name_pair: 16'h0, type_code: batsp_pkg::TYPE_A, value: 32'h0};
                n++;
                prs_closed = 1'b1;
            end
            for (int i = 0; i < n; i++)
                pending_res.push_back('{res: res[i], run_end: (i == n - 1)});
        end
    endtask

    task automatic add_byte(input logic [7:0] data, input logic fin);
        t_aux_byte a;
        a.data = data;
        a.fin  = fin;
        aux_bytes.push_back(a);
    endtask

    // header plus value; fin_last flags the tag's last byte as final
    task automatic add_tag(input logic [15:0] name, input logic [3:0] code,
                           input logic [31:0] val, input int str_len, input logic fin_last);
        int k;
        add_byte(name[15:8], 1'b0);
        add_byte(name[7:0], 1'b0);
        add_byte(TYPE_CHAR[code], 1'b0);
        if (code == batsp_pkg::TYPE_Z) begin
            for (k = 0; k < str_len; k++)
                add_byte(8'($urandom_range(255, 1)), 1'b0);
            add_byte(batsp_pkg::NUL_BYTE, fin_last);
        end else begin
            for (k = 0; k < TYPE_LEN[code]; k++)
                add_byte(val[8 * k +: 8], fin_last && (k == TYPE_LEN[code] - 1));
        end
    endtask

    // driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        logic calm;
        calm = (beats_in >= 150) && (beats_in < 250);
        if (i_rst_n) begin
            if (!in_if.valid || in_taken) begin
                if (aux_bytes.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
                    in_if.valid      <= 1'b1;
                    in_if.byte_value <= aux_bytes[0].data;
                    in_if.final_byte <= aux_bytes[0].fin;
                    aux_bytes.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            out_if.ready <= calm || ($urandom_range(99) >= 26);
        end
    end

    // monitor: predict on each input beat, check each output beat
    always @(posedge i_clk) begin
        t_result_beat got;
        t_result_beat want;
        logic         in_fire;
        logic         out_fire;
        in_fire  = i_rst_n && in_if.valid && in_if.ready;
        out_fire = i_rst_n && out_if.valid && out_if.ready;
        in_taken <= in_fire;
        if (in_fire) begin
            beats_in++;
            parse_byte(in_if.byte_value, in_if.final_byte);
        end
        if (out_fire) begin
            got = '{res: '{kind: out_if.kind, name_pair: out_if.name_pair,
                           type_code: out_if.type_code, value: out_if.value},
                    run_end: out_if.run_end};
            if (pending_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: kind %0d name %h type %0d value %h end %b",
                             got.res.kind, got.res.name_pair, got.res.type_code,
                             got.res.value, got.run_end);
            end else begin
                want = pending_res.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %h %0d %h %b, got %0d %h %0d %h %b",
                                 want.res.kind, want.res.name_pair, want.res.type_code,
                                 want.res.value, want.run_end,
                                 got.res.kind, got.res.name_pair, got.res.type_code,
                                 got.res.value, got.run_end);
                end
            end
        end
        // watchdog on lack of progress
        if (!i_rst_n || in_fire || out_fire)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int         mode;
        logic [3:0] code;
        logic [7:0] bad_type;

        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.byte_value = 8'h00;
        in_if.final_byte = 1'b0;
        out_if.ready     = 1'b0;
        in_taken         = 1'b0;
        beats_in         = 0;
        quiet_cycles     = 0;
        mismatches       = 0;

        prs_state    = ST_SKIP_LEAD;
        prs_name     = '0;
        prs_type     = batsp_pkg::TYPE_A;
        prs_acc      = '0;
        prs_left     = 0;
        prs_tag_seen = 1'b0;
        prs_closed   = 1'b0;

        // junk around the alphanumeric ranges is skipped
        add_byte(8'h00, 1'b0);
        add_byte(8'hff, 1'b0);
        add_byte(8'h2f, 1'b0);
        add_byte(8'h3a, 1'b0);
        add_byte(8'h40, 1'b0);
        add_byte(8'h5b, 1'b0);
        add_byte(8'h60, 1'b0);
        add_byte(8'h7b, 1'b0);
        // first header with alphanumeric edges, then value extremes
        add_tag({"z", "9"}, batsp_pkg::TYPE_UC, 32'h0000_00ff, 0, 1'b0);
        add_tag(16'h00ff, batsp_pkg::TYPE_LC, 32'h0000_0080, 0, 1'b0);
        add_tag(16'hff00, batsp_pkg::TYPE_UI, 32'hffff_ffff, 0, 1'b0);
        add_tag({"0", "A"}, batsp_pkg::TYPE_Z, 32'h0, 0, 1'b0);   // empty string

        // random well-formed tags
        while (aux_bytes.size() < BYTE_COUNT) begin
            code = 4'($urandom_range(8));
            case ($urandom_range(5))
                0:       add_tag(16'($urandom), code, 32'h0, $urandom_range(6), 1'b0);
                1:       add_tag(16'($urandom), code, 32'hffff_ffff, $urandom_range(6), 1'b0);
                default: add_tag(16'($urandom), code, $urandom, $urandom_range(6), 1'b0);
            endcase
        end

        // one way of ending the list
        mode = $urandom_range(5);
        code = 4'($urandom_range(8));
        case (mode)
            0: begin
                // zero type byte after a complete tag
                add_byte(8'($urandom), 1'b0);
                add_byte(8'($urandom), 1'b0);
                add_byte(batsp_pkg::NUL_BYTE, 1'b0);
            end
            1: begin
                // zero type byte that is also the final byte
                add_byte(8'($urandom), 1'b0);
                add_byte(8'($urandom), 1'b0);
                add_byte(batsp_pkg::NUL_BYTE, 1'b1);
            end
            2: begin
                // unknown type letter, the unparsed array and hex types among them
                case ($urandom_range(3))
                    0:       bad_type = 8'h48;  // H
                    1:       bad_type = 8'h42;  // B
                    2:       bad_type = 8'hff;
                    default: bad_type = 8'h61;  // a
                endcase
                add_byte(8'($urandom), 1'b0);
                add_byte(8'($urandom), 1'b0);
                add_byte(bad_type, 1'($urandom_range(1)));
            end
            3: begin
                // final byte completes a tag: tag result then accept
                add_tag(16'($urandom), code, $urandom, $urandom_range(3), 1'b1);
            end
            4: begin
                // truncated inside a four-byte value
                add_byte(8'($urandom), 1'b0);
                add_byte(8'($urandom), 1'b0);
                add_byte(TYPE_CHAR[batsp_pkg::TYPE_LI], 1'b0);
                add_byte(8'($urandom), 1'b0);
                add_byte(8'($urandom), 1'b1);
            end
            default: begin
                // truncated after the first name byte
                add_byte(8'($urandom), 1'b1);
            end
        endcase
        // a closed list drops everything
        add_byte(8'($urandom), 1'b0);
        add_byte(8'($urandom), 1'b1);
        add_byte(8'($urandom), 1'b0);
        add_byte(batsp_pkg::NUL_BYTE, 1'b1);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (aux_bytes.size() != 0 || in_if.valid || pending_res.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_res.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
